// ===== sv/sort_key_normalizer_defines.svh =====
// Assertion helpers used by the sort key normalizer top module.
`ifndef SORT_KEY_NORMALIZER_DEFINES_SVH
`define SORT_KEY_NORMALIZER_DEFINES_SVH

// Same-cycle implication, checked on every edge outside reset.
`define SKN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every edge outside reset.
`define SKN_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/skn_pkg.sv =====
`default_nettype none

package skn_pkg;

  // Store geometry
  localparam int RECORD_BYTES    = 256;
  localparam int ADDR_W          = $clog2(RECORD_BYTES);
  localparam int FILL_W          = $clog2(RECORD_BYTES + 1);
  localparam int START_W         = 8;
  localparam int PTR_W           = START_W + 1;

  // Key limits
  localparam int MAX_FIELDS      = 4;
  localparam int FIELD_W         = $clog2(MAX_FIELDS);
  localparam int MAX_KEY_BYTES   = 64;
  localparam int CNT_W           = $clog2(MAX_KEY_BYTES + 1);
  localparam int MAX_FIELD_BYTES = 32;
  localparam int SIZE_W          = 6;
  localparam int IDX_W           = $clog2(MAX_FIELD_BYTES);
  localparam int SUM_W           = SIZE_W + 2;

  // Configuration port
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 17;
  localparam int COUNT_W         = 3;
  localparam logic [CFG_DATA_W-1:0] DESC_RESET = 17'd256;
  localparam logic [COUNT_W-1:0]    COUNT_RESET = 3'd1;

  localparam logic [7:0] SIGN_BIT = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_COUNT = 3'd0,
    CFG_FIELD0      = 3'd1,
    CFG_FIELD1      = 3'd2,
    CFG_FIELD2      = 3'd3,
    CFG_FIELD3      = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FT_TEXT     = 2'd0,
    FT_UNSIGNED = 2'd1,
    FT_SIGNED   = 2'd2,
    FT_REAL     = 2'd3
  } field_type_t;

  typedef enum logic [1:0] {
    S_LOAD = 2'd0,
    S_READ = 2'd1,
    S_DATA = 2'd2,
    S_HOLD = 2'd3
  } state_t;

  // Decoded view of the configuration registers
  typedef struct packed {
    logic [COUNT_W-1:0]                   nf;
    logic [MAX_FIELDS-1:0][START_W-1:0]   start;
    logic [MAX_FIELDS-1:0][SIZE_W-1:0]    size;
    field_type_t [MAX_FIELDS-1:0]         ftype;
    logic [MAX_FIELDS-1:0]                desc;
    logic [CNT_W-1:0]                     total;
  } cfg_view_t;

endpackage

`default_nettype wire

// ===== sv/skn_ram.sv =====
`default_nettype none

module skn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/skn_cfg.sv =====
`default_nettype none

module skn_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [skn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [skn_pkg::CFG_DATA_W-1:0] cfg_data,
  output skn_pkg::cfg_view_t             view
);

  logic [skn_pkg::COUNT_W-1:0]    count_r;
  logic [skn_pkg::CFG_DATA_W-1:0] desc_r [skn_pkg::MAX_FIELDS];
  logic [skn_pkg::SUM_W-1:0]      sum;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= skn_pkg::COUNT_RESET;
      for (int k = 0; k < skn_pkg::MAX_FIELDS; k++) begin
        desc_r[k] <= skn_pkg::DESC_RESET;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        skn_pkg::CFG_FIELD_COUNT: count_r   <= cfg_data[skn_pkg::COUNT_W-1:0];
        skn_pkg::CFG_FIELD0:      desc_r[0] <= cfg_data;
        skn_pkg::CFG_FIELD1:      desc_r[1] <= cfg_data;
        skn_pkg::CFG_FIELD2:      desc_r[2] <= cfg_data;
        skn_pkg::CFG_FIELD3:      desc_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode descriptors, clamp sizes and count, total the key length and clamp it to the key limit
  always_comb begin
    view.nf = (count_r > skn_pkg::COUNT_W'(skn_pkg::MAX_FIELDS))
            ? skn_pkg::COUNT_W'(skn_pkg::MAX_FIELDS) : count_r;
    sum = '0;
    for (int k = 0; k < skn_pkg::MAX_FIELDS; k++) begin
      view.start[k] = desc_r[k][7:0];
      view.size[k]  = (desc_r[k][13:8] > skn_pkg::SIZE_W'(skn_pkg::MAX_FIELD_BYTES))
                    ? skn_pkg::SIZE_W'(skn_pkg::MAX_FIELD_BYTES) : desc_r[k][13:8];
      view.ftype[k] = skn_pkg::field_type_t'(desc_r[k][15:14]);
      view.desc[k]  = desc_r[k][16];
      if (skn_pkg::COUNT_W'(k) < view.nf) begin
        sum = sum + skn_pkg::SUM_W'(view.size[k]);
      end
    end
    view.total = (sum > skn_pkg::SUM_W'(skn_pkg::MAX_KEY_BYTES))
               ? skn_pkg::CNT_W'(skn_pkg::MAX_KEY_BYTES) : sum[skn_pkg::CNT_W-1:0];
  end

endmodule

`default_nettype wire

// ===== sv/sort_key_normalizer.sv =====
// Loading: one record byte accepted per cycle; in_stall stays low while loading.
// Key: if the key length is non-zero, after the final record byte is accepted each key byte
// goes through store read, format and handoff (S_READ, S_DATA, S_HOLD); handoff waits out output stalls.
// Input is stalled from the final record byte until the last key byte is taken.
// Reset: fill count cleared, registers return to defaults; store contents are kept.
`default_nettype none
`include "sort_key_normalizer_defines.svh"

module sort_key_normalizer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_record_byte,
  input  logic                           in_record_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_key_byte,
  output logic                           out_key_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [skn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [skn_pkg::CFG_DATA_W-1:0] cfg_data
);

  skn_pkg::cfg_view_t view;
  skn_pkg::state_t    state_r, state_nxt;

  logic [skn_pkg::FILL_W-1:0]  fill_r;
  logic [skn_pkg::FIELD_W-1:0] fld_r;
  logic [skn_pkg::IDX_W-1:0]   idx_r;
  logic [skn_pkg::CNT_W-1:0]   cnt_r;
  logic                        neg_r;
  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  logic                        out_last_r;

  logic                        in_acc;
  logic                        ram_we, ram_re;
  logic [7:0]                  ram_rdata;
  logic [skn_pkg::PTR_W-1:0]   ptr;
  logic [skn_pkg::START_W-1:0] cur_start;
  logic [skn_pkg::SIZE_W-1:0]  cur_size;
  skn_pkg::field_type_t        cur_type;
  logic                        cur_desc;
  logic [7:0]                  rd_byte;
  logic                        idx0;
  logic                        neg_now;
  logic [7:0]                  fmt;
  logic                        field_done;
  logic                        key_done;

  skn_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .view      (view)
  );

  skn_ram #(
    .WIDTH (8),
    .DEPTH (skn_pkg::RECORD_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[skn_pkg::ADDR_W-1:0]),
    .wdata (in_record_byte),
    .re    (ram_re),
    .raddr (ptr[skn_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // First field at or after 'from' that is in use and has bytes
  function automatic logic [skn_pkg::FIELD_W-1:0] seek_field(
    input skn_pkg::cfg_view_t v,
    input logic [skn_pkg::COUNT_W-1:0] from
  );
    logic [skn_pkg::FIELD_W-1:0] sel;
    logic                        hit;
    sel = '0;
    hit = 1'b0;
    for (int k = 0; k < skn_pkg::MAX_FIELDS; k++) begin
      if (!hit && skn_pkg::COUNT_W'(k) >= from && skn_pkg::COUNT_W'(k) < v.nf &&
          v.size[k] != '0) begin
        sel = skn_pkg::FIELD_W'(k);
        hit = 1'b1;
      end
    end
    return sel;
  endfunction

  assign in_acc = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      skn_pkg::S_LOAD: begin
        if (in_acc && in_record_end && view.total != '0) begin
          state_nxt = skn_pkg::S_READ;
        end
      end
      skn_pkg::S_READ: state_nxt = skn_pkg::S_DATA;
      skn_pkg::S_DATA: state_nxt = skn_pkg::S_HOLD;
      skn_pkg::S_HOLD: begin
        if (!out_stall) begin
          state_nxt = out_last_r ? skn_pkg::S_LOAD : skn_pkg::S_READ;
        end
      end
      default: state_nxt = skn_pkg::S_LOAD;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = (state_r != skn_pkg::S_LOAD);
    ram_re   = (state_r == skn_pkg::S_READ);
    ram_we   = in_acc && (fill_r < skn_pkg::FILL_W'(skn_pkg::RECORD_BYTES));
  end

  // Store address of the current key byte
  always_comb begin
    cur_start = view.start[fld_r];
    cur_size  = view.size[fld_r];
    cur_type  = view.ftype[fld_r];
    cur_desc  = view.desc[fld_r];
    if (cur_type == skn_pkg::FT_TEXT) begin
      ptr = skn_pkg::PTR_W'(cur_start) + skn_pkg::PTR_W'(idx_r);
    end else begin
      ptr = skn_pkg::PTR_W'(cur_start) + skn_pkg::PTR_W'(cur_size) - skn_pkg::PTR_W'(1)
          - skn_pkg::PTR_W'(idx_r);
    end
  end

  // Format the byte read from the store
  always_comb begin
    rd_byte = (ptr >= skn_pkg::PTR_W'(skn_pkg::RECORD_BYTES)) ? 8'h00 : ram_rdata;
    idx0    = (idx_r == '0);
    neg_now = idx0 ? rd_byte[7] : neg_r;
    case (cur_type)
      skn_pkg::FT_SIGNED: fmt = idx0 ? (rd_byte ^ skn_pkg::SIGN_BIT) : rd_byte;
      skn_pkg::FT_REAL: begin
        if (neg_now) begin
          fmt = ~rd_byte;
        end else begin
          fmt = idx0 ? (rd_byte ^ skn_pkg::SIGN_BIT) : rd_byte;
        end
      end
      default: fmt = rd_byte;
    endcase
    fmt        = fmt ^ {8{cur_desc}};
    field_done = ((skn_pkg::SIZE_W'(idx_r) + skn_pkg::SIZE_W'(1)) == cur_size);
    key_done   = ((cnt_r + skn_pkg::CNT_W'(1)) == view.total);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skn_pkg::S_LOAD;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (in_record_end) begin
          fill_r <= '0;
          cnt_r  <= '0;
        end else if (ram_we) begin
          fill_r <= fill_r + skn_pkg::FILL_W'(1);
        end
      end
      if (state_r == skn_pkg::S_DATA) begin
        out_valid_r <= 1'b1;
        cnt_r       <= cnt_r + skn_pkg::CNT_W'(1);
      end else if (state_r == skn_pkg::S_HOLD && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sequencer and output payload
  always_ff @(posedge clk) begin
    if (in_acc && in_record_end) begin
      fld_r <= seek_field(view, '0);
      idx_r <= '0;
    end
    if (state_r == skn_pkg::S_DATA) begin
      out_byte_r <= fmt;
      out_last_r <= key_done;
      neg_r      <= neg_now;
      if (field_done) begin
        idx_r <= '0;
        fld_r <= seek_field(view, skn_pkg::COUNT_W'(fld_r) + skn_pkg::COUNT_W'(1));
      end else begin
        idx_r <= idx_r + skn_pkg::IDX_W'(1);
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_byte = out_byte_r;
  assign out_key_last = out_last_r;

  `SKN_ASSERT_IMP(a_no_load_during_key, in_acc, !out_valid_r,
                  "record byte accepted while a key byte is pending")
  `SKN_ASSERT_IMP(a_valid_in_hold, out_valid_r, state_r == skn_pkg::S_HOLD,
                  "key byte valid outside the hold state")
  `SKN_ASSERT_NXT(a_last_returns, out_valid_r && !out_stall && out_last_r,
                  state_r == skn_pkg::S_LOAD && !out_valid_r,
                  "block did not return to loading after the last key byte")
  `SKN_ASSERT_IMP(a_key_limit, state_r == skn_pkg::S_DATA,
                  cnt_r < skn_pkg::CNT_W'(skn_pkg::MAX_KEY_BYTES),
                  "key byte count past the key limit")
  `SKN_ASSERT_IMP(a_fill_limit, 1'b1, fill_r <= skn_pkg::FILL_W'(skn_pkg::RECORD_BYTES),
                  "fill count past the store depth")

endmodule

`default_nettype wire

// ===== tb/sv/tb_sort_key_normalizer.sv =====
`timescale 1ns / 1ps

module tb_sort_key_normalizer;
  import skn_pkg::*;

  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    logic [7:0] data;
    logic       is_end;
  } record_req_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } key_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_record_byte = 8'h00;
  logic                  in_record_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_key_byte;
  logic                  out_key_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the block: record store, fill pointer, registers
  logic [7:0]            rec_image [RECORD_BYTES];
  int unsigned           fill_count = 0;
  logic [COUNT_W-1:0]    field_count = COUNT_RESET;
  logic [CFG_DATA_W-1:0] field_desc [MAX_FIELDS] = '{default: DESC_RESET};

  record_req_t byte_requests [$];
  key_byte_t   key_bytes_due [$];
  int          key_mismatches = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  sort_key_normalizer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_record_byte (in_record_byte),
    .in_record_end  (in_record_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_byte   (out_key_byte),
    .out_key_last   (out_key_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] stored_byte(input int unsigned addr);
    if (addr >= RECORD_BYTES) return 8'h00;
    return rec_image[addr];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] field_word(input int unsigned start,
                                                      input int unsigned size,
                                                      input field_type_t ft,
                                                      input logic descending);
    return {descending, ft, 6'(size), 8'(start)};
  endfunction

  // Store one record byte; on the final byte build the expected key
  task automatic load_record_byte(input logic [7:0] data, input logic is_end);
    int unsigned nfld, start, size, nkey;
    field_type_t ftype;
    logic [7:0]  flip, v, top;
    logic        neg;
    if (fill_count < RECORD_BYTES) begin
      rec_image[fill_count] = data;
      fill_count++;
    end
    if (!is_end) return;
    fill_count = 0;
    nfld = (field_count > MAX_FIELDS) ? MAX_FIELDS : field_count;
    nkey = 0;
    for (int f = 0; f < nfld; f++) begin
      start = field_desc[f][7:0];
      size  = field_desc[f][13:8];
      ftype = field_type_t'(field_desc[f][15:14]);
      flip  = field_desc[f][16] ? 8'hFF : 8'h00;
      if (size > MAX_FIELD_BYTES) size = MAX_FIELD_BYTES;
      if (size == 0) continue;
      top = stored_byte(start + size - 1);
      neg = (ftype == FT_REAL) && top[7];
      for (int i = 0; i < size; i++) begin
        if (ftype == FT_TEXT) begin
          v = stored_byte(start + i);
        end else begin
          v = stored_byte(start + size - 1 - i);
          if (ftype == FT_SIGNED && i == 0) begin
            v ^= SIGN_BIT;
          end else if (ftype == FT_REAL) begin
            if (neg) v = ~v;
            else if (i == 0) v ^= SIGN_BIT;
          end
        end
        // Drop key bytes past the key limit
        if (nkey < MAX_KEY_BYTES) begin
          key_bytes_due.push_back('{data: v ^ flip, last: 1'b0});
          nkey++;
        end
      end
    end
    if (nkey > 0) key_bytes_due[key_bytes_due.size() - 1].last = 1'b1;
  endtask

  task automatic log_mismatch(input string what, input key_byte_t due);
    key_mismatches++;
    if (key_mismatches <= 10)
      $display("%0t: %s: expected byte %02h last %b, got byte %02h last %b",
               $time, what, due.data, due.last, out_key_byte, out_key_last);
  endtask

  // Present queued record bytes; hold each request until it is taken
  always @(posedge clk) begin : record_driver
    record_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) load_record_byte(in_record_byte, in_record_end);
      if (!in_valid || !in_stall) begin
        if (byte_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = byte_requests.pop_front();
          in_valid       <= 1'b1;
          in_record_byte <= nxt.data;
          in_record_end  <= nxt.is_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each key byte taken against the oldest one due
  always @(posedge clk) begin : key_check
    key_byte_t due;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (key_bytes_due.size() == 0) begin
          log_mismatch("unexpected key byte", '{data: 8'h00, last: 1'b0});
        end else begin
          due = key_bytes_due.pop_front();
          if (out_key_byte !== due.data || out_key_last !== due.last)
            log_mismatch("key byte mismatch", due);
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_FIELD_COUNT) field_count = val[COUNT_W-1:0];
    else if (idx <= CFG_FIELD3) field_desc[int'(idx) - 1] = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_literal(input logic [127:0] bytes, input int n);
    for (int i = 0; i < n; i++)
      byte_requests.push_back('{data: bytes[8*(n-1-i) +: 8], is_end: (i == n - 1)});
  endtask

  task automatic queue_random_record(input int len);
    logic [7:0] b;
    int         roll;
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(0, 19);
      b = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom);
      byte_requests.push_back('{data: b, is_end: (i == len - 1)});
    end
  endtask

  task automatic program_random_fields();
    logic [COUNT_W-1:0] cnt;
    int unsigned        start, size;
    int                 roll;
    cnt = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
    write_reg(CFG_FIELD_COUNT, {14'($urandom), cnt});
    for (int f = 0; f < MAX_FIELDS; f++) begin
      start = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 31) : $urandom_range(0, 255);
      roll  = $urandom_range(0, 99);
      size  = (roll < 85) ? $urandom_range(0, 12) :
              (roll < 95) ? $urandom_range(13, 40) : $urandom_range(41, 63);
      write_reg(3'(int'(CFG_FIELD0) + f),
                field_word(start, size, field_type_t'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1))));
    end
  endtask

  // Wait until every request is taken and every key byte has arrived
  task automatic wait_idle();
    @(posedge clk);
    while (byte_requests.size() != 0 || in_valid || key_bytes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int len, sent, roll;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the whole store with an over-long record under the reset setup
    queue_random_record(RECORD_BYTES + 4);
    wait_idle();

    // One field of each type, mixed directions
    write_reg(CFG_FIELD_COUNT, 17'(4));
    write_reg(CFG_FIELD0, field_word(0, 4, FT_TEXT, 1'b0));
    write_reg(CFG_FIELD1, field_word(4, 2, FT_UNSIGNED, 1'b1));
    write_reg(CFG_FIELD2, field_word(6, 2, FT_SIGNED, 1'b0));
    write_reg(CFG_FIELD3, field_word(8, 4, FT_REAL, 1'b0));
    queue_literal(128'h00FF417F_34120080_000080BF, 12);
    wait_idle();

    // Positive real, descending; one-byte record reads stale bytes
    write_reg(CFG_FIELD3, field_word(4, 2, FT_REAL, 1'b1));
    queue_literal(128'hFF, 1);
    wait_idle();

    // Largest values: clamped count and size, reads past the store, key overflow
    write_reg(CFG_FIELD_COUNT, 17'h1FFFF);
    for (int f = 0; f < MAX_FIELDS; f++)
      write_reg(3'(int'(CFG_FIELD0) + f), 17'h1FFFF);
    queue_literal(128'h0080, 2);
    wait_idle();

    // Empty key: no fields, then zero-size fields of every type
    write_reg(CFG_FIELD_COUNT, 17'(0));
    for (int f = 0; f < MAX_FIELDS; f++)
      write_reg(3'(int'(CFG_FIELD0) + f), 17'(0));
    queue_literal(128'h5A, 1);
    wait_idle();
    write_reg(CFG_FIELD_COUNT, 17'(4));
    write_reg(CFG_FIELD1, field_word(3, 0, FT_UNSIGNED, 1'b1));
    write_reg(CFG_FIELD2, field_word(5, 0, FT_SIGNED, 1'b0));
    write_reg(CFG_FIELD3, field_word(7, 0, FT_REAL, 1'b1));
    for (int k = int'(CFG_FIELD3) + 1; k < 8; k++)
      write_reg(3'(k), 17'($urandom));
    queue_literal(128'hA5, 1);
    wait_idle();

    // Random records under random setups, one idling mode at a time
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      for (int s = 0; s < 2; s++) begin
        program_random_fields();
        sent = 0;
        while (sent < 4) begin
          roll = $urandom_range(0, 99);
          len = (roll < 90) ? $urandom_range(1, 6) : $urandom_range(7, 20);
          queue_random_record(len);
          sent += len;
        end
        wait_idle();
      end
    end

    if (key_mismatches == 0 && key_bytes_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/skn_pkg.sv
sv/skn_ram.sv
sv/skn_cfg.sv
sv/sort_key_normalizer.sv
tb/sv/tb_sort_key_normalizer.sv
